// ===== src/rrw_pkg.sv =====
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared types and fixed field widths of the receive reorder window tracker.
// ----------------------------------------------------------------------------
package rrw_pkg;

	localparam int SEQ_W      = 24;
	localparam int LEN_W      = 16;
	localparam int TS_W       = 48;
	localparam int WIN_W      = 6;
	localparam int SLOT_OUT_W = 6;
	localparam int ADM_W      = 5;

	localparam logic [WIN_W-1:0] WIN_RESET = 6'd32;
	localparam logic [ADM_W-1:0] ADM_MAX   = 5'd31;

	localparam logic OP_POST   = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	typedef enum logic [2:0] {
		ST_POSTED    = 3'd0,
		ST_PENDING   = 3'd1,
		ST_ACCEPTED  = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_NOT_OPEN  = 3'd4,
		ST_MISMATCH  = 3'd5,
		ST_PEND_FULL = 3'd6
	} status_t;

endpackage

// ===== src/rrw_ram.sv =====
// ----------------------------------------------------------------------------
// rrw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rrw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/rrw_slot_reduce.sv =====
// ----------------------------------------------------------------------------
// rrw_slot_reduce
// Iterative compare/subtract unit: reduces a small offset modulo SLOTS.
// ----------------------------------------------------------------------------
module rrw_slot_reduce #(
	parameter int SLOTS  = 64,
	parameter int VAL_W  = 7,
	parameter int SLOT_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [VAL_W-1:0]  value,
	output logic              done,
	output logic [SLOT_W-1:0] result
);

	logic             busy_q;
	logic [VAL_W-1:0] val_q;

	assign done   = busy_q && (val_q < VAL_W'(SLOTS));
	assign result = val_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
		end else if (busy_q && !done) begin
			val_q <= val_q - VAL_W'(SLOTS);
		end
	end

endmodule

// ===== src/receive_reorder_window_top.sv =====
// ----------------------------------------------------------------------------
// receive_reorder_window_top
// Receive window tracker: posts expected lengths, checks arriving packets.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: a post (operation 0) or
// an arrived packet (operation 1). Each word yields exactly one result word on
// the output channel (out_valid/out_ready). window_size is written through the
// cfg channel (cfg_valid/cfg_ready, always ready); the user must write it
// only while the block is idle, the block itself does not enforce this.
// One word is processed at a time; in_ready is high only when idle.
// Steps from the accepting edge until the result word is loaded:
// Post: a full queue goes straight to the result; otherwise the admission
// loop (S_ADM_RD, S_ADM_WR) admits pending entries. Packet outside the
// window: straight to the result. Packet inside: slot reduction (S_MOD,
// subtract steps of SLOTS, 0 or 1 when SLOTS >= 64), length RAM read
// (S_LOOKUP), check (S_CHECK), tail walk over the slots the tail advances
// (S_TAIL), then the admission loop as for a post.
// in_ready returns once the result is loaded into the output register.
// Results sit in an output register; a new word is accepted while a result
// waits, but a finished word stalls until the output register drains.
// Reset clears the sequence pointers, open flags, newest timestamp and the
// pending queue, and sets window_size to 32. The length stores are not
// cleared; only written entries are read.
// ----------------------------------------------------------------------------
module receive_reorder_window_top
	import rrw_pkg::*;
#(
	parameter int SLOTS         = 64,
	parameter int PENDING_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	input  logic [LEN_W-1:0]      post_length,
	input  logic [SEQ_W-1:0]      packet_sn,
	input  logic [LEN_W-1:0]      pkt_length,
	input  logic [TS_W-1:0]       packet_ts,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [SLOT_OUT_W-1:0] slot,
	output logic [SEQ_W-1:0]      assigned_sn,
	output logic [SEQ_W-1:0]      window_start_sn,
	output logic [TS_W-1:0]       newest_ts,
	output logic [ADM_W-1:0]      admitted_count,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [WIN_W-1:0]      cfg_data
);

	localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RED_W   = $clog2(SLOTS + 64);
	localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNT_W   = $clog2(PENDING_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_LOOKUP,
		S_CHECK,
		S_TAIL,
		S_ADM_RD,
		S_ADM_WR,
		S_FINISH
	} state_t;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s,
			input logic seq_zero);
		logic [SLOT_W-1:0] r;
		if (seq_zero || s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	function automatic logic [PEND_AW-1:0] ptr_inc(input logic [PEND_AW-1:0] p);
		logic [PEND_AW-1:0] r;
		if (p == PEND_AW'(PENDING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	state_t               state_q;
	logic [WIN_W-1:0]     window_q;
	logic [SEQ_W-1:0]     head_q;
	logic [SEQ_W-1:0]     tail_q;
	logic [SLOT_W-1:0]    head_slot_q;
	logic [SLOT_W-1:0]    tail_slot_q;
	logic [SLOTS-1:0]     open_q;
	logic [TS_W-1:0]      newest_q;
	logic [CNT_W-1:0]     pend_cnt_q;
	logic [PEND_AW-1:0]   wr_ptr_q;
	logic [PEND_AW-1:0]   rd_ptr_q;

	logic                 op_q;
	logic [LEN_W-1:0]     len_q;
	logic [TS_W-1:0]      ts_q;
	status_t              res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [SEQ_W-1:0]     assigned_q;
	logic [ADM_W-1:0]     adm_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic [SEQ_W-1:0]     out_assigned_q;
	logic [SEQ_W-1:0]     out_tail_q;
	logic [TS_W-1:0]      out_newest_q;
	logic [ADM_W-1:0]     out_adm_q;

	logic                 accept;
	logic                 out_load;
	logic                 pend_full;
	logic [SEQ_W-1:0]     sn_off;
	logic                 in_win;
	logic                 wrapped;
	logic [RED_W-1:0]     red_value;
	logic                 red_start;
	logic                 red_done;
	logic [SLOT_W-1:0]    red_result;
	logic [SEQ_W-1:0]     occ;
	logic                 admit_ok;
	logic [SEQ_W-1:0]     head_next;
	logic [SEQ_W-1:0]     tail_next;
	logic                 tail_stop;
	logic                 exp_we;
	logic                 pend_we;
	logic [LEN_W-1:0]     exp_rdata;
	logic [LEN_W-1:0]     pend_rdata;
	logic [SLOT_W+5:0]    slot_ext;

	assign accept    = in_valid && in_ready;
	assign out_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	assign pend_full = pend_cnt_q >= CNT_W'(PENDING_DEPTH);
	assign sn_off    = packet_sn - tail_q;
	assign in_win    = sn_off < SEQ_W'(window_q);
	assign wrapped   = packet_sn < tail_q;
	assign red_value = wrapped ? RED_W'(packet_sn[5:0])
	                           : RED_W'(tail_slot_q) + RED_W'(sn_off[5:0]);
	assign red_start = accept && (operation == OP_PACKET) && in_win;
	assign occ       = head_q - tail_q;
	assign admit_ok  = (pend_cnt_q != '0) && (occ <= SEQ_W'(window_q))
	                   && (occ < SEQ_W'(SLOTS));
	assign head_next = head_q + 1'b1;
	assign tail_next = tail_q + 1'b1;
	assign tail_stop = (tail_q == head_q) || open_q[tail_slot_q];
	assign exp_we    = (state_q == S_ADM_WR) && admit_ok;
	assign pend_we   = accept && (operation == OP_POST) && !pend_full;

	rrw_slot_reduce #(
		.SLOTS  (SLOTS),
		.VAL_W  (RED_W),
		.SLOT_W (SLOT_W)
	) u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (red_start),
		.value  (red_value),
		.done   (red_done),
		.result (red_result)
	);

	rrw_ram #(
		.WIDTH (LEN_W),
		.DEPTH (SLOTS)
	) u_exp_ram (
		.clk   (clk),
		.we    (exp_we),
		.waddr (head_slot_q),
		.wdata (pend_rdata),
		.raddr (res_slot_q),
		.rdata (exp_rdata)
	);

	rrw_ram #(
		.WIDTH (LEN_W),
		.DEPTH (PENDING_DEPTH)
	) u_pend_ram (
		.clk   (clk),
		.we    (pend_we),
		.waddr (wr_ptr_q),
		.wdata (post_length),
		.raddr (rd_ptr_q),
		.rdata (pend_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			window_q    <= WIN_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			open_q      <= '0;
			newest_q    <= '0;
			pend_cnt_q  <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				window_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q       <= operation;
						len_q      <= pkt_length;
						ts_q       <= packet_ts;
						adm_q      <= '0;
						res_slot_q <= '0;
						assigned_q <= (operation == OP_POST && !pend_full)
						              ? head_q + SEQ_W'(pend_cnt_q) : '0;
						if (operation == OP_POST) begin
							if (pend_full) begin
								res_status_q <= ST_PEND_FULL;
								state_q      <= S_FINISH;
							end else begin
								wr_ptr_q   <= ptr_inc(wr_ptr_q);
								pend_cnt_q <= pend_cnt_q + 1'b1;
								state_q    <= S_ADM_RD;
							end
						end else if (!in_win) begin
							res_status_q <= ST_OUTSIDE;
							state_q      <= S_FINISH;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (red_done) begin
						res_slot_q <= red_result;
						state_q    <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (!open_q[res_slot_q]) begin
						res_status_q <= ST_NOT_OPEN;
					end else if (exp_rdata != len_q) begin
						res_status_q <= ST_MISMATCH;
					end else begin
						res_status_q       <= ST_ACCEPTED;
						open_q[res_slot_q] <= 1'b0;
						if (ts_q > newest_q) begin
							newest_q <= ts_q;
						end
					end
					state_q <= S_TAIL;
				end
				S_TAIL: begin
					if (tail_stop) begin
						state_q <= S_ADM_RD;
					end else begin
						tail_q      <= tail_next;
						tail_slot_q <= slot_inc(tail_slot_q, tail_next == '0);
					end
				end
				S_ADM_RD: begin
					state_q <= S_ADM_WR;
				end
				S_ADM_WR: begin
					if (admit_ok) begin
						open_q[head_slot_q] <= 1'b1;
						head_q      <= head_next;
						head_slot_q <= slot_inc(head_slot_q, head_next == '0);
						rd_ptr_q    <= ptr_inc(rd_ptr_q);
						pend_cnt_q  <= pend_cnt_q - 1'b1;
						if (adm_q != ADM_MAX) begin
							adm_q <= adm_q + 1'b1;
						end
						if (op_q == OP_POST) begin
							res_slot_q <= head_slot_q;
						end
						state_q <= S_ADM_RD;
					end else begin
						if (op_q == OP_POST) begin
							if (pend_cnt_q == '0) begin
								res_status_q <= ST_POSTED;
							end else begin
								res_status_q <= ST_PENDING;
								res_slot_q   <= '0;
							end
						end
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_load) begin
						out_status_q   <= res_status_q;
						out_slot_q     <= res_slot_q;
						out_assigned_q <= assigned_q;
						out_tail_q     <= tail_q;
						out_newest_q   <= newest_q;
						out_adm_q      <= adm_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign slot_ext        = {6'd0, out_slot_q};
	assign slot            = slot_ext[SLOT_OUT_W-1:0];
	assign assigned_sn     = out_assigned_q;
	assign window_start_sn = out_tail_q;
	assign newest_ts       = out_newest_q;
	assign admitted_count  = out_adm_q;

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= CNT_W'(PENDING_DEPTH))
		else $error("pending count above queue depth");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ <= SEQ_W'(SLOTS))
		else $error("open span exceeds slot store");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FINISH))
		else $error("result word raised outside finish");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready right after accepting a word");

endmodule
